FILE: src/ipv4dq_pkg.sv
`default_nettype none

package ipv4dq_pkg;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_BAD_CHAR  = 3'd1;
    localparam status_t ST_TOO_LONG  = 3'd2;
    localparam status_t ST_OVER_255  = 3'd3;
    localparam status_t ST_EMPTY     = 3'd4;
    localparam status_t ST_COUNT     = 3'd5;
    localparam status_t ST_NONCONTIG = 3'd6;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2e;

    localparam logic [9:0] OCTET_MAX   = 10'd255;
    localparam logic [1:0] MAX_DIGITS  = 2'd3;
    localparam logic [1:0] DOTS_NEEDED = 2'd3;

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t REG_PARSE_MODE = 1'b0;
    localparam cfg_index_t REG_NETMASK    = 1'b1;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_string;
    } char_word_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] value;
        logic [31:0] host_part;
    } res_word_t;

endpackage

`default_nettype wire

FILE: src/ipv4_dotted_quad_parser.sv
// a character is registered in s1, then parsed into the parse state as it
// leaves s1; the result word is registered as the end of string leaves s1
// throughput: one character per cycle, but end of string waits for out_free
// reset: rst_n clears parse state, valids, parse_mode and netmask to zero
`default_nettype none

module ipv4_dotted_quad_parser (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    char_valid,
    output logic                         char_ready,
    input  wire ipv4dq_pkg::char_word_t  char_word,
    output logic                         res_valid,
    input  wire logic                    res_ready,
    output ipv4dq_pkg::res_word_t        res_word,
    input  wire logic                    cfg_we,
    input  wire ipv4dq_pkg::cfg_index_t  cfg_index,
    input  wire logic [31:0]             cfg_wdata
);
    import ipv4dq_pkg::*;

    logic        parse_mode_reg;
    logic [31:0] netmask_reg;

    logic       s1_valid_reg;
    char_word_t s1_word_reg;

    logic [9:0]  acc_reg,  acc_next;
    logic [1:0]  dig_reg,  dig_next;
    logic [1:0]  dots_reg, dots_next;
    logic [31:0] val_reg,  val_next;
    status_t     err_reg,  err_next;

    logic      out_valid_reg;
    res_word_t out_reg, out_next;

    logic       s1_fire;
    logic       out_free;
    logic       is_digit;
    logic [3:0] digit;
    logic [31:0] final_val;
    logic [31:0] inv_val;
    status_t     fin_status;

    assign out_free   = !out_valid_reg || res_ready;
    assign s1_fire    = s1_valid_reg && (!s1_word_reg.end_of_string || out_free);
    assign char_ready = !s1_valid_reg || s1_fire;
    assign res_valid  = out_valid_reg;
    assign res_word   = out_reg;

    assign is_digit = (s1_word_reg.char_in >= CHAR_ZERO) && (s1_word_reg.char_in <= CHAR_NINE);
    assign digit    = 4'(s1_word_reg.char_in - CHAR_ZERO);

    // character step
    always_comb
    begin
        acc_next  = acc_reg;
        dig_next  = dig_reg;
        dots_next = dots_reg;
        val_next  = val_reg;
        err_next  = err_reg;
        if (err_reg == ST_OK)
        begin
            if (is_digit)
            begin
                if (dig_reg == MAX_DIGITS)
                begin
                    err_next = ST_TOO_LONG;
                end
                else
                begin
                    // acc * 10 + digit, acc is at most 99 here
                    acc_next = {acc_reg[6:0], 3'b000} + {acc_reg[8:0], 1'b0}
                             + {6'd0, digit};
                    dig_next = dig_reg + 2'd1;
                end
            end
            else if (s1_word_reg.char_in == CHAR_DOT)
            begin
                if (dig_reg == 2'd0)
                begin
                    err_next = ST_EMPTY;
                end
                else if (acc_reg > OCTET_MAX)
                begin
                    err_next = ST_OVER_255;
                end
                else if (dots_reg == DOTS_NEEDED)
                begin
                    err_next = ST_COUNT;
                end
                else
                begin
                    val_next  = {val_reg[23:0], acc_reg[7:0]};
                    dots_next = dots_reg + 2'd1;
                    acc_next  = 10'd0;
                    dig_next  = 2'd0;
                end
            end
            else
            begin
                err_next = ST_BAD_CHAR;
            end
        end
    end

    // end-of-string checks on the updated state
    always_comb
    begin
        fin_status = err_next;
        final_val  = {val_next[23:0], acc_next[7:0]};
        if (fin_status == ST_OK)
        begin
            if (dots_next != DOTS_NEEDED)
                fin_status = ST_COUNT;
            else if (dig_next == 2'd0)
                fin_status = ST_EMPTY;
            else if (acc_next > OCTET_MAX)
                fin_status = ST_OVER_255;
        end
        inv_val = ~final_val;
        // contiguous ones then zeros: inverted value is of the form 0..01..1
        if ((fin_status == ST_OK) && parse_mode_reg
            && ((inv_val & (inv_val + 32'd1)) != 32'd0))
            fin_status = ST_NONCONTIG;

        out_next.status = fin_status;
        if (fin_status == ST_OK)
        begin
            out_next.value     = final_val;
            out_next.host_part = final_val & ~netmask_reg;
        end
        else
        begin
            out_next.value     = 32'd0;
            out_next.host_part = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_mode_reg <= 1'b0;
            netmask_reg    <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PARSE_MODE: parse_mode_reg <= cfg_wdata[0];
                REG_NETMASK:    netmask_reg    <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (char_ready)
            s1_valid_reg <= char_valid;
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
            s1_word_reg <= char_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= 10'd0;
            dig_reg  <= 2'd0;
            dots_reg <= 2'd0;
            val_reg  <= 32'd0;
            err_reg  <= ST_OK;
        end
        else if (s1_fire)
        begin
            if (s1_word_reg.end_of_string)
            begin
                acc_reg  <= 10'd0;
                dig_reg  <= 2'd0;
                dots_reg <= 2'd0;
                val_reg  <= 32'd0;
                err_reg  <= ST_OK;
            end
            else
            begin
                acc_reg  <= acc_next;
                dig_reg  <= dig_next;
                dots_reg <= dots_next;
                val_reg  <= val_next;
                err_reg  <= err_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_word_reg.end_of_string)
            out_valid_reg <= 1'b1;
        else if (res_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_word_reg.end_of_string)
            out_reg <= out_next;
    end

`ifndef NO_ASSERTIONS
    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != ST_OK))
        |-> ((out_reg.value == 32'd0) && (out_reg.host_part == 32'd0)))
        else $error("failed result word carries nonzero value");

    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg <= 10'd999)
        else $error("octet accumulator out of range");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_fire && s1_word_reg.end_of_string))
        else $error("result word without end of string");

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_word_reg.end_of_string)
        |=> ((dig_reg == 2'd0) && (dots_reg == 2'd0) && (err_reg == ST_OK)))
        else $error("parse state not cleared after end of string");
`endif

endmodule

`default_nettype wire

FILE: verif/ipv4dq_checker.sv
`timescale 1ns / 1ps

module ipv4dq_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_valid,
    input  logic                    char_ready,
    input  ipv4dq_pkg::char_word_t  char_word,
    input  logic                    res_valid,
    input  logic                    res_ready,
    input  ipv4dq_pkg::res_word_t   res_word,
    input  logic                    cfg_we,
    input  ipv4dq_pkg::cfg_index_t  cfg_index,
    input  logic [31:0]             cfg_wdata,
    output int                      fail_count,
    output int                      checked_count,
    output int                      pending_count
);
    import ipv4dq_pkg::*;

    // shadow copy of the configuration
    logic        mask_mode;
    logic [31:0] netmask_q;

    // shadow parse state
    logic [9:0]  octet_acc;
    logic [1:0]  digits_seen;
    logic [1:0]  dots_seen;
    logic [31:0] quad_so_far;
    status_t     first_err;

    res_word_t   expected_words[$];
    res_word_t   want;

    task automatic clear_parse();
        octet_acc   = '0;
        digits_seen = '0;
        dots_seen   = '0;
        quad_so_far = '0;
        first_err   = ST_OK;
    endtask

    task automatic absorb_char(input logic [7:0] c);
        if (first_err != ST_OK)
            return;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            if (digits_seen >= MAX_DIGITS)
                first_err = ST_TOO_LONG;
            else
            begin
                octet_acc   = octet_acc * 10'd10 + 10'(c - CHAR_ZERO);
                digits_seen = digits_seen + 2'd1;
            end
        end
        else if (c == CHAR_DOT)
        begin
            if (digits_seen == 2'd0)
                first_err = ST_EMPTY;
            else if (octet_acc > OCTET_MAX)
                first_err = ST_OVER_255;
            else if (dots_seen >= DOTS_NEEDED)
                first_err = ST_COUNT;
            else
            begin
                quad_so_far = {quad_so_far[23:0], octet_acc[7:0]};
                dots_seen   = dots_seen + 2'd1;
                octet_acc   = '0;
                digits_seen = '0;
            end
        end
        else
            first_err = ST_BAD_CHAR;
    endtask

    function automatic res_word_t close_string();
        res_word_t   r;
        status_t     st;
        logic [31:0] val;
        logic [31:0] inv;
        st  = first_err;
        val = '0;
        if (st == ST_OK)
        begin
            if (dots_seen != DOTS_NEEDED)
                st = ST_COUNT;
            else if (digits_seen == 2'd0)
                st = ST_EMPTY;
            else if (octet_acc > OCTET_MAX)
                st = ST_OVER_255;
            else
                val = {quad_so_far[23:0], octet_acc[7:0]};
        end
        // a mask must be ones then zeros, so its inverse plus one is a power of two or wraps to zero
        if (st == ST_OK && mask_mode)
        begin
            inv = ~val;
            if ((inv & (inv + 32'd1)) != 32'd0)
                st = ST_NONCONTIG;
        end
        if (st != ST_OK)
            val = '0;
        r.status    = st;
        r.value     = val;
        r.host_part = (st == ST_OK) ? (val & ~netmask_q) : 32'd0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            mask_mode     = 1'b0;
            netmask_q     = '0;
            expected_words.delete();
            fail_count    = 0;
            checked_count = 0;
            pending_count = 0;
        end
        else
        begin
            // result word first: it belongs to a string finished earlier
            if (res_valid && res_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got %0d/%h/%h",
                             $time, res_word.status, res_word.value, res_word.host_part);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    checked_count++;
                    if (res_word.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, res_word.status);
                        fail_count++;
                    end
                    if (res_word.value !== want.value)
                    begin
                        $display("%0t: value mismatch, expected %h, got %h",
                                 $time, want.value, res_word.value);
                        fail_count++;
                    end
                    if (res_word.host_part !== want.host_part)
                    begin
                        $display("%0t: host_part mismatch, expected %h, got %h",
                                 $time, want.host_part, res_word.host_part);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_PARSE_MODE)
                    mask_mode = cfg_wdata[0];
                else
                    netmask_q = cfg_wdata;
            end
            if (char_valid && char_ready)
            begin
                absorb_char(char_word.char_in);
                if (char_word.end_of_string)
                begin
                    expected_words.push_back(close_string());
                    clear_parse();
                end
            end
            pending_count = expected_words.size();
        end
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import ipv4dq_pkg::*;

    localparam int CYCLE_LIMIT = 250000;
    localparam int PHASE_ITEMS = 210;
    localparam int NUM_PHASES  = 6;

    logic        clk;
    logic        rst_n;
    logic        char_valid;
    logic        char_ready;
    char_word_t  char_word;
    logic        res_valid;
    logic        res_ready;
    res_word_t   res_word;
    logic        cfg_we;
    cfg_index_t  cfg_index;
    logic [31:0] cfg_wdata;

    int fail_count;
    int checked_count;
    int pending_count;

    int  cycle_count = 0;
    int  chars_sent  = 0;
    int  strings_sent = 0;
    bit  calm = 0;        // no idling on either side
    bit  line_gaps = 0;   // sender may idle within the current string
    bit  mode_now = 0;

    logic [7:0] line_q[$];

    ipv4_dotted_quad_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_word  (char_word),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_word   (res_word),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    ipv4dq_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_ready    (char_ready),
        .char_word     (char_word),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_word      (res_word),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .checked_count (checked_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // receiver: ready drops in random bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
                res_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    task automatic push_char(input logic [7:0] c, input logic eos);
        if (line_gaps && !calm && $urandom_range(0, 5) == 0)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        char_valid <= 1'b1;
        char_word  <= {c, eos};
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
        @(negedge clk);
        chars_sent++;
    endtask

    task automatic send_line();
        if (line_q.size() == 0)
            line_q.push_back(CHAR_ZERO);
        line_gaps = $urandom_range(0, 2) != 0;
        foreach (line_q[i])
            push_char(line_q[i], i == line_q.size() - 1);
        line_q.delete();
        strings_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
        send_line();
    endtask

    // wait until every result word is back, then let the pipe settle
    task automatic drain();
        char_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(negedge clk);
    endtask

    task automatic set_config(input bit m, input logic [31:0] nm);
        write_reg(REG_PARSE_MODE, {31'($urandom), m});
        write_reg(REG_NETMASK, nm);
        cfg_we   <= 1'b0;
        mode_now = m;
    endtask

    function automatic logic [31:0] ones_then_zeros(input int n);
        return ~(32'hFFFF_FFFF >> n);
    endfunction

    task automatic add_octet(input int v, input bit pad);
        if (pad || v >= 100)
            line_q.push_back(CHAR_ZERO + 8'(v / 100));
        if (pad || v >= 10)
            line_q.push_back(CHAR_ZERO + 8'((v / 10) % 10));
        line_q.push_back(CHAR_ZERO + 8'(v % 10));
    endtask

    task automatic add_quad(input logic [31:0] v);
        for (int k = 0; k < 4; k++)
        begin
            if (k > 0)
                line_q.push_back(CHAR_DOT);
            if ($urandom_range(0, 11) == 0)
                add_octet($urandom_range(256, 999), 1'b0);
            else
                add_octet(int'(v[31 - 8 * k -: 8]), $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic break_line();
        int pos;
        pos = $urandom_range(0, line_q.size() - 1);
        case ($urandom_range(0, 5))
            0: line_q[pos] = 8'($urandom_range(0, 255));
            1: line_q.delete(pos);
            2: line_q.insert(pos, CHAR_DOT);
            3: line_q.insert(pos, CHAR_ZERO + 8'($urandom_range(0, 9)));
            4: while (line_q.size() > pos + 1) void'(line_q.pop_back());
            default:
            begin
                line_q.push_back(CHAR_DOT);
                add_octet($urandom_range(0, 255), 1'b0);
            end
        endcase
    endtask

    task automatic random_line();
        int          kind;
        logic [31:0] v;
        kind = $urandom_range(0, 19);
        if (mode_now || $urandom_range(0, 3) == 0)
        begin
            v = ones_then_zeros($urandom_range(0, 32));
            if ($urandom_range(0, 3) == 0)
                v[$urandom_range(0, 31)] ^= 1'b1;
        end
        else
            v = $urandom;
        if (kind < 11)
            add_quad(v);
        else if (kind < 17)
        begin
            add_quad(v);
            repeat ($urandom_range(1, 2)) break_line();
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                if ($urandom_range(0, 1) == 0)
                    line_q.push_back(8'($urandom_range(0, 255)));
                else if ($urandom_range(0, 3) == 0)
                    line_q.push_back(CHAR_DOT);
                else
                    line_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        send_line();
    endtask

    initial
    begin
        int phase_start;
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_word  = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_PARSE_MODE;
        cfg_wdata  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // host mode under reset settings
        send_text("0.0.0.0");
        send_text("255.255.255.255");
        send_text("1.2.3.4x");
        push_char(8'h00, 1'b1);
        send_text("1.2.3.1234");
        send_text("1.2.256.4");
        send_text("1.2.3.999");
        send_text("1..3.4");
        send_text("1.2.3.");
        send_text("1.2.3.4.5");
        send_text("1.2.3");
        send_text("1a.2.3.4");
        drain();
        set_config(1'b0, 32'hFFFF_FF00);
        send_text("192.168.1.77");
        drain();
        // mask mode
        set_config(1'b1, 32'hFFFF_FFFF);
        send_text("255.255.0.0");
        send_text("255.0.255.0");
        send_text("0.0.0.0");
        send_text("255.255.255.254");
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: set_config(1'b0, 32'h0000_0000);
                1: set_config(1'b0, 32'hFFFF_FFFF);
                2: set_config(1'b1, 32'hFFFF_FF00);
                3: set_config(1'b0, $urandom);
                4: set_config(1'b1, $urandom);
                default:
                begin
                    calm = 1'b1;
                    set_config(1'($urandom_range(0, 1)),
                               ones_then_zeros($urandom_range(0, 32)));
                end
            endcase
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_ITEMS)
                random_line();
            drain();
        end

        $display("tb: %0d strings in %0d characters, %0d result words checked",
                 strings_sent, chars_sent, checked_count);
        $display("tb: host and mask modes, netmask zero to all ones, malformed and noise strings");
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
